// ===== rtl/assert_macros.svh =====
// assertion macros shared by the frame ring rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every edge outside reset
`define UITF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition on one edge implies a second condition on the next edge
`define UITF_ASSERT_NEXT(lbl, clk, rst, cond, nxt, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

// ===== rtl/uitf_pkg.sv =====
// types and fixed constants of the uart idle-timeout frame ring
// no dependencies; imported by the top level
`timescale 1ns / 1ps

package uitf_pkg;

   localparam int OP_W       = 2;
   localparam int BYTE_W     = 8;
   localparam int CNT_W      = 16;
   localparam int KIND_W     = 2;
   localparam int RING_W     = 2;
   localparam int RSP_DATA_W = 48;

   localparam logic [CNT_W-1:0] IDLE_LIMIT_RESET = 16'd5;

   typedef enum logic [OP_W-1:0] {
      OP_BYTE  = 2'd0,
      OP_TICK  = 2'd1,
      OP_DRAIN = 2'd2,
      OP_DONE  = 2'd3
   } uitf_op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_STATUS = 2'd0,
      KIND_BYTE   = 2'd1,
      KIND_EMPTY  = 2'd2
   } uitf_kind_type;

   typedef enum logic [RING_W-1:0] {
      RING_EMPTY = 2'd0,
      RING_SOME  = 2'd1,
      RING_FULL  = 2'd2
   } uitf_ring_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_EXEC  = 2'd1,
      ST_DRAIN = 2'd2
   } uitf_state_type;

endpackage

// ===== rtl/uitf_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies; used for frame bytes and frame lengths
`timescale 1ns / 1ps

module uitf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/uart_idle_timeout_frame_fifo_core.sv =====
// top level of the uart idle-timeout frame ring
// depends on uitf_pkg, uitf_ram and assert_macros.svh
`timescale 1ns / 1ps

// Usage
// req channel: tuser carries the op (byte received, time tick, drain one
// frame, transmit done), tdata carries the received byte. rsp channel: one
// status transfer for byte, tick and transmit done; a drain gives the frame
// bytes in order with tlast on the final one, or one empty-marker transfer.
// Every rsp transfer carries the ring status as it stands after the item.
// csr port writes the idle limit (ticks after the last byte before an open
// frame closes); write it only while the block is idle.
// Steps: taking an item reads the frame length memory at the write slot
// (read slot for a drain); executing it updates the state and loads the
// output register once that is free. A drain then streams the frame bytes
// from the frame memory through its registered read, one byte per cycle
// while the receiver takes them. One item is in work at a time; the next is
// taken once the last result is loaded and the output register is free or being read.
// Reset clears all control state at once: frame length entries are covered by
// one valid bit per slot, so there is no clearing pass; frame bytes are
// undefined until written. A stalled receiver holds the output register and
// the sequencer waits; nothing is dropped.

module uart_idle_timeout_frame_fifo_core
   import uitf_pkg::*;
#(
   parameter int FRAME_SLOTS = 8,
   parameter int FRAME_BYTES = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] rx_byte
   input  logic [OP_W-1:0]       req_tuser,   // [1:0] op
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] data_byte, [8] notify_sender,
                                              // [10:9] ring_state, [11] rx_stopped_flag,
                                              // [27:12] overflow_count,
                                              // [43:28] drained_empty_count, [47:44] zero
   output logic [KIND_W-1:0]     rsp_tuser,   // [1:0] kind
   output logic                  rsp_tlast,   // last_byte
   // configuration
   input  logic                  csr_wr_en,
   input  logic [CNT_W-1:0]      csr_wr_data
);

`include "assert_macros.svh"

   localparam int SLOT_W = $clog2(FRAME_SLOTS);
   localparam int LEN_W  = $clog2(FRAME_BYTES + 1);
   localparam int DEPTH  = FRAME_SLOTS * FRAME_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_SLOTS - 1);
   localparam logic [LEN_W-1:0]  BYTES_L   = LEN_W'(FRAME_BYTES);
   localparam logic [LEN_W:0]    BYTES_X   = (LEN_W + 1)'(FRAME_BYTES);
   localparam logic [ADDR_W-1:0] BYTES_A   = ADDR_W'(FRAME_BYTES);

   // sequencer and item registers
   uitf_state_type    state_ff, state_in;
   uitf_op_type       op_ff, op_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   // ring control state
   logic [SLOT_W-1:0]      ws_ff, ws_in;
   logic [SLOT_W-1:0]      rs_ff, rs_in;
   uitf_ring_type          ring_ff, ring_in;
   logic                   halted_ff, halted_in;
   logic                   busy_ff, busy_in;
   logic                   armed_ff, armed_in;
   logic [CNT_W-1:0]       ticks_ff, ticks_in;
   logic [CNT_W-1:0]       full_cnt_ff, full_cnt_in;
   logic [CNT_W-1:0]       empty_cnt_ff, empty_cnt_in;
   logic [CNT_W-1:0]       limit_ff;
   logic [FRAME_SLOTS-1:0] len_valid_ff, len_valid_in;

   // drain streaming
   logic [LEN_W-1:0]  drain_len_ff, drain_len_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [LEN_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic [LEN_W-1:0]  emit_cnt_ff, emit_cnt_in;
   logic              pend_ff, pend_in;

   // output register
   logic              rsp_valid_ff;
   uitf_kind_type     rsp_kind_ff;
   logic [BYTE_W-1:0] rsp_data_ff;
   logic              rsp_last_ff;
   logic              rsp_note_ff;
   uitf_ring_type     rsp_ring_ff;
   logic              rsp_halt_ff;
   logic [CNT_W-1:0]  rsp_full_ff;
   logic [CNT_W-1:0]  rsp_empty_ff;

   logic              out_free;
   logic              out_load;
   uitf_kind_type     out_kind;
   logic [BYTE_W-1:0] out_data;
   logic              out_last;
   logic              out_note;

   // memory ports
   logic              len_rd_en;
   logic [SLOT_W-1:0] len_rd_addr;
   logic [LEN_W-1:0]  len_rdata;
   logic              len_wr_en;
   logic [LEN_W-1:0]  len_wdata;
   logic              st_wr_en;
   logic [ADDR_W-1:0] st_wr_addr;
   logic              st_rd_en;
   logic [ADDR_W-1:0] st_rd_addr;
   logic [BYTE_W-1:0] st_rdata;

   uitf_ram #(
      .WIDTH (LEN_W),
      .DEPTH (FRAME_SLOTS)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_wr_en),
      .wr_addr (slot_ff),
      .wr_data (len_wdata),
      .rd_en   (len_rd_en),
      .rd_addr (len_rd_addr),
      .rd_data (len_rdata)
   );

   uitf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (byte_ff),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state, memory accesses and result selection
   always_comb begin
      logic [LEN_W-1:0]  len_cur;
      logic [LEN_W-1:0]  len_clip;
      logic [LEN_W:0]    len_inc;
      logic [ADDR_W-1:0] base_w;
      logic [SLOT_W-1:0] ws_nx;
      logic [SLOT_W-1:0] rs_nx;
      logic              do_close;
      logic              move;
      logic              issue;

      state_in     = state_ff;
      op_in        = op_ff;
      byte_in      = byte_ff;
      slot_in      = slot_ff;
      ws_in        = ws_ff;
      rs_in        = rs_ff;
      ring_in      = ring_ff;
      halted_in    = halted_ff;
      busy_in      = busy_ff;
      armed_in     = armed_ff;
      ticks_in     = ticks_ff;
      full_cnt_in  = full_cnt_ff;
      empty_cnt_in = empty_cnt_ff;
      len_valid_in = len_valid_ff;
      drain_len_in = drain_len_ff;
      base_in      = base_ff;
      rd_cnt_in    = rd_cnt_ff;
      emit_cnt_in  = emit_cnt_ff;
      pend_in      = pend_ff;

      req_tready  = 1'b0;
      len_rd_en   = 1'b0;
      len_rd_addr = ws_ff;
      len_wr_en   = 1'b0;
      st_wr_en    = 1'b0;
      st_rd_en    = 1'b0;
      st_rd_addr  = base_ff + ADDR_W'(rd_cnt_ff);

      out_load = 1'b0;
      out_kind = KIND_STATUS;
      out_data = '0;
      out_last = 1'b1;
      out_note = 1'b0;

      len_cur    = len_valid_ff[slot_ff] ? len_rdata : '0;
      len_clip   = (len_cur > BYTES_L) ? BYTES_L : len_cur;
      len_inc    = {1'b0, len_cur} + 1'b1;
      len_wdata  = len_inc[LEN_W-1:0];
      base_w     = ADDR_W'(slot_ff) * BYTES_A;
      st_wr_addr = base_w + ADDR_W'(len_cur);
      ws_nx      = (ws_ff == LAST_SLOT) ? '0 : ws_ff + 1'b1;
      rs_nx      = (rs_ff == LAST_SLOT) ? '0 : rs_ff + 1'b1;
      do_close   = 1'b0;
      move       = 1'b0;
      issue      = 1'b0;

      unique case (state_ff)
         // take an item and read the length of the slot it touches
         ST_IDLE: begin
            req_tready = out_free;
            if (req_tvalid && out_free) begin
               op_in       = uitf_op_type'(req_tuser);
               byte_in     = req_tdata;
               len_rd_en   = 1'b1;
               len_rd_addr = (uitf_op_type'(req_tuser) == OP_DRAIN) ? rs_ff : ws_ff;
               slot_in     = len_rd_addr;
               state_in    = ST_EXEC;
            end
         end

         // length is in hand: update the ring and load the result, or start streaming a drained frame
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
               unique case (op_ff)
                  OP_BYTE: begin
                     out_load = 1'b1;
                     if (!halted_ff) begin
                        st_wr_en                = (len_cur < BYTES_L);
                        len_wr_en               = 1'b1;
                        len_valid_in[slot_ff]   = 1'b1;
                        do_close                = (len_inc >= BYTES_X);
                     end
                  end
                  OP_TICK: begin
                     out_load = 1'b1;
                     if (armed_ff) begin
                        ticks_in = (ticks_ff == '1) ? ticks_ff : ticks_ff + 1'b1;
                        if (ticks_in >= limit_ff) begin
                           armed_in = 1'b0;
                           do_close = (len_cur != '0) && !halted_ff;
                        end
                     end
                  end
                  OP_DRAIN: begin
                     if (ring_ff == RING_EMPTY) begin
                        out_load = 1'b1;
                        out_kind = KIND_EMPTY;
                     end else begin
                        // advance the read slot now; results report the final state
                        if (rs_nx == ws_ff) begin
                           ring_in      = RING_EMPTY;
                           empty_cnt_in = empty_cnt_ff + 1'b1;
                           rs_in        = rs_nx;
                           if (halted_ff) begin
                              ws_in           = '0;
                              rs_in           = '0;
                              busy_in         = 1'b0;
                              halted_in       = 1'b0;
                              armed_in        = 1'b0;
                              ticks_in        = '0;
                              len_valid_in[0] = 1'b0;
                           end
                        end else begin
                           ring_in = RING_SOME;
                           rs_in   = rs_nx;
                        end
                        if (len_clip == '0) begin
                           out_load = 1'b1;
                        end else begin
                           drain_len_in = len_clip;
                           base_in      = base_w;
                           rd_cnt_in    = '0;
                           emit_cnt_in  = '0;
                           pend_in      = 1'b0;
                           state_in     = ST_DRAIN;
                        end
                     end
                  end
                  OP_DONE: begin
                     out_load = 1'b1;
                     busy_in  = 1'b0;
                  end
               endcase

               // close the open frame and step the write slot
               if (do_close) begin
                  ws_in = ws_nx;
                  if (ws_nx == rs_ff) begin
                     full_cnt_in = full_cnt_ff + 1'b1;
                     ring_in     = RING_FULL;
                     halted_in   = 1'b1;
                  end else begin
                     ring_in             = RING_SOME;
                     len_valid_in[ws_nx] = 1'b0;
                  end
                  if (!busy_ff) begin
                     busy_in  = 1'b1;
                     out_note = 1'b1;
                  end
               end

               // an accepted byte rearms the idle timer unless the ring filled
               if (op_ff == OP_BYTE && !halted_ff) begin
                  armed_in = !halted_in;
                  if (!halted_in) begin
                     ticks_in = '0;
                  end
               end
            end
         end

         // stream the frame bytes from the store
         ST_DRAIN: begin
            move  = pend_ff && out_free;
            issue = (rd_cnt_ff < drain_len_ff) && (!pend_ff || move);
            if (move) begin
               out_load    = 1'b1;
               out_kind    = KIND_BYTE;
               out_data    = st_rdata;
               out_last    = (emit_cnt_ff + 1'b1 == drain_len_ff);
               emit_cnt_in = emit_cnt_ff + 1'b1;
               if (out_last) begin
                  state_in = ST_IDLE;
               end
            end
            if (issue) begin
               st_rd_en  = 1'b1;
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            pend_in = issue ? 1'b1 : (move ? 1'b0 : pend_ff);
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ws_ff        <= '0;
         rs_ff        <= '0;
         ring_ff      <= RING_EMPTY;
         halted_ff    <= 1'b0;
         busy_ff      <= 1'b0;
         armed_ff     <= 1'b0;
         ticks_ff     <= '0;
         full_cnt_ff  <= '0;
         empty_cnt_ff <= '0;
         limit_ff     <= IDLE_LIMIT_RESET;
         len_valid_ff <= '0;
         pend_ff      <= 1'b0;
         rd_cnt_ff    <= '0;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ws_ff        <= ws_in;
         rs_ff        <= rs_in;
         ring_ff      <= ring_in;
         halted_ff    <= halted_in;
         busy_ff      <= busy_in;
         armed_ff     <= armed_in;
         ticks_ff     <= ticks_in;
         full_cnt_ff  <= full_cnt_in;
         empty_cnt_ff <= empty_cnt_in;
         len_valid_ff <= len_valid_in;
         pend_ff      <= pend_in;
         rd_cnt_ff    <= rd_cnt_in;
         emit_cnt_ff  <= emit_cnt_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      byte_ff      <= byte_in;
      slot_ff      <= slot_in;
      drain_len_ff <= drain_len_in;
      base_ff      <= base_in;
      if (out_load) begin
         rsp_kind_ff  <= out_kind;
         rsp_data_ff  <= out_data;
         rsp_last_ff  <= out_last;
         rsp_note_ff  <= out_note;
         rsp_ring_ff  <= ring_in;
         rsp_halt_ff  <= halted_in;
         rsp_full_ff  <= full_cnt_in;
         rsp_empty_ff <= empty_cnt_in;
      end
   end

   // response ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0000, rsp_empty_ff, rsp_full_ff, rsp_halt_ff, rsp_ring_ff,
                        rsp_note_ff, rsp_data_ff};

   // checks
   `UITF_ASSERT(a_full_is_halted, clock, reset, (ring_ff == RING_FULL) |-> halted_ff, "full ring while reception runs")
   `UITF_ASSERT(a_halted_not_empty, clock, reset, !(halted_ff && (ring_ff == RING_EMPTY)), "halted ring left empty")
   `UITF_ASSERT(a_drain_counts, clock, reset, (state_ff == ST_DRAIN) |-> (rd_cnt_ff == emit_cnt_ff + LEN_W'(pend_ff)), "drain read and emit counts out of step")
   `UITF_ASSERT_NEXT(a_accept_exec, clock, reset, req_tvalid && req_tready, state_ff == ST_EXEC, "accepted item not executed next cycle")

endmodule
